// ===== rtl/core/llta_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llta_pkg
// Shared types and constants for the least-loaded tower assigner.
// ----------------------------------------------------------------------------
package llta_pkg;

    localparam int MAX_TOWERS  = 16;
    localparam int LOAD_WIDTH  = 32;
    localparam int HEIGHT_W    = 16;
    localparam int TOWER_W     = 5;
    localparam int BIN_IDX_W   = (MAX_TOWERS > 1) ? $clog2(MAX_TOWERS) : 1;
    localparam int CNT_W       = $clog2(MAX_TOWERS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                new_batch;
        logic [HEIGHT_W-1:0] block_height;
    } t_in_item;

    typedef struct packed {
        logic [TOWER_W-1:0] tower_index;
        logic               load_saturated;
    } t_out_item;

    // queue head as seen by the back end
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_queue_head;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_back_state;

endpackage
`default_nettype wire

// ===== rtl/core/llta_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llta_front
// Accepts transactions into a short queue and holds the bin-count register,
// whose output is clamped to the usable range.
// ----------------------------------------------------------------------------
module llta_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  llta_pkg::t_in_item           i_item,
    input  wire                          i_cfg_we,
    input  wire  [llta_pkg::TOWER_W-1:0] i_cfg_data,
    input  wire                          i_pop,
    output llta_pkg::t_queue_head        o_head,
    output logic [llta_pkg::CNT_W-1:0]   o_active
);
    import llta_pkg::*;

    t_in_item            r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_cnt;
    logic [TOWER_W-1:0]  r_num_towers;
    logic                w_push;
    logic                w_pop;

    assign busy   = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign w_push = start && !busy;
    assign w_pop  = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rptr];

    always_comb begin
        if (r_num_towers == '0) begin
            o_active = CNT_W'(1);
        end else if (32'(r_num_towers) > 32'(MAX_TOWERS)) begin
            o_active = CNT_W'(MAX_TOWERS);
        end else begin
            o_active = CNT_W'(r_num_towers);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr       <= '0;
            r_rptr       <= '0;
            r_cnt        <= '0;
            r_num_towers <= TOWER_W'(1);
        end else begin
            if (i_cfg_we) begin
                r_num_towers <= i_cfg_data;
            end
            if (w_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/llta_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// llta_back
// Holds the bin loads, scans the active bins one per cycle for the least
// loaded one, then adds the height with saturation and issues the result.
// ----------------------------------------------------------------------------
module llta_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  llta_pkg::t_queue_head        i_head,
    input  wire  [llta_pkg::CNT_W-1:0]   i_active,
    output logic                         o_pop,
    output logic                         o_valid,
    output llta_pkg::t_out_item          o_result
);
    import llta_pkg::*;

    t_back_state             r_state;
    t_back_state             n_state;
    logic [LOAD_WIDTH-1:0]   r_load [MAX_TOWERS];
    logic [CNT_W-1:0]        r_idx;
    logic [BIN_IDX_W-1:0]    r_best;
    logic [LOAD_WIDTH-1:0]   r_best_load;
    logic [HEIGHT_W-1:0]     r_height;
    logic                    r_valid;
    t_out_item               r_result;

    logic                    w_finish;
    logic [LOAD_WIDTH-1:0]   w_cand;
    logic [LOAD_WIDTH:0]     w_sum;
    logic                    w_sat;
    logic                    w_clear;
    logic                    w_write;

    assign w_finish = (r_idx >= i_active);
    assign w_cand   = r_load[r_idx[BIN_IDX_W-1:0]];
    assign w_sum    = {1'b0, r_best_load} + (LOAD_WIDTH + 1)'(r_height);
    assign w_sat    = w_sum[LOAD_WIDTH];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        w_clear = 1'b0;
        w_write = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pop   = i_head.valid;
                w_clear = i_head.valid && i_head.item.new_batch;
            end
            ST_SCAN: begin
                w_write = w_finish;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TOWERS; i++) begin
                r_load[i] <= '0;
            end
        end else if (w_clear) begin
            for (int i = 0; i < MAX_TOWERS; i++) begin
                r_load[i] <= '0;
            end
        end else if (w_write) begin
            r_load[r_best] <= w_sat ? {LOAD_WIDTH{1'b1}} : w_sum[LOAD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_idx       <= CNT_W'(1);
            r_best      <= '0;
            r_best_load <= i_head.item.new_batch ? '0 : r_load[0];
            r_height    <= i_head.item.block_height;
        end else if (r_state == ST_SCAN && !w_finish) begin
            r_idx <= r_idx + CNT_W'(1);
            if (w_cand < r_best_load) begin
                r_best      <= r_idx[BIN_IDX_W-1:0];
                r_best_load <= w_cand;
            end
        end
        if (w_write) begin
            r_result.tower_index    <= TOWER_W'({1'b0, r_best} + (BIN_IDX_W + 1)'(1));
            r_result.load_saturated <= w_sat;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== rtl/core/least_loaded_tower_assigner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// least_loaded_tower_assigner
// Greedy least-loaded bin assignment with saturating per-bin loads.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive i_item and raise start; the transaction is taken on a clock
//   edge where start is high and busy is low. busy rises when the two-entry
//   input queue is full.
//   Output: each result sits on o_result for exactly one cycle, marked by
//   o_valid. The receiver cannot stall; results are never held.
//   Config: i_cfg_we with i_cfg_data writes the bin count (0 acts as 1,
//   values above 16 act as 16). Write only while the block is idle.
//   Back end: it scans one bin per cycle and works on one item at a time; it
//   pops the next item from the queue only in its idle state, after the scan
//   of the current item ends. o_valid is registered, set from the last scan
//   step.
//   Reset: synchronous, active low; clears the queue, all bin loads, and sets
//   the bin count to 1.
// ----------------------------------------------------------------------------
module least_loaded_tower_assigner (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  llta_pkg::t_in_item           i_item,
    input  wire                          i_cfg_we,
    input  wire  [llta_pkg::TOWER_W-1:0] i_cfg_data,
    output logic                         o_valid,
    output llta_pkg::t_out_item          o_result
);
    import llta_pkg::*;

    t_queue_head        w_head;
    logic [CNT_W-1:0]   w_active;
    logic               w_pop;

    llta_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_active   (w_active)
    );

    llta_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_active (w_active),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
